[design/assert_macros.svh]
// Assertion macros shared by the RTL of the substring search block.
// Every check is clocked on clk_i and held off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define BSS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication from a trigger to a consequence in the next cycle.
`define BSS_ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cons)) \
    else $error(msg);

`endif

[design/bss_pkg.sv]
// Package of the substring search block: widths, types, register indexes
// and the case folding function. No dependencies.
`timescale 1ns / 1ps

package bss_pkg;

  localparam int unsigned NEEDLE_MAX_DEF = 8;
  localparam int unsigned NEEDLE_W      = 64;
  localparam int unsigned LEN_W         = 4;
  localparam int unsigned OFFSET_W      = 32;
  localparam int unsigned CFG_IDX_W     = 2;

  localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_BYTES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NEEDLE_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FOLD_CASE     = 2'd2;

  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
  localparam logic [7:0] ASCII_CASE_OFS = 8'h20;

  typedef struct packed {
    logic [NEEDLE_W-1:0] needle;
    logic [LEN_W-1:0]    len;     // already clamped to the cell count
    logic                fold;
  } needle_cfg_t;

  typedef struct packed {
    logic shift;  // take the neighbour's byte
    logic clear;  // end of haystack: empty the window
  } cell_ctrl_t;

  typedef struct packed {
    logic                found;
    logic [OFFSET_W-1:0] offset;
  } result_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
    logic [7:0] r;
    r = c;
    if (en && c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) begin
      r = c + ASCII_CASE_OFS;
    end
    return r;
  endfunction

endpackage

[design/bss_cell.sv]
// One window cell: holds one haystack byte, hands it on to the next cell
// and compares its incoming byte with the needle byte it lines up with.
// Depends on bss_pkg.
`timescale 1ns / 1ps

module bss_cell import bss_pkg::*; #(
  parameter int unsigned CELL_IDX = 0
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cell_ctrl_t  ctrl_i,
  input  needle_cfg_t cfg_i,
  input  logic [7:0]  byte_i,
  output logic [7:0]  byte_o,
  output logic        eq_o
);

  localparam logic [LEN_W-1:0] Idx = LEN_W'(CELL_IDX);

  logic [7:0]       byte_q, byte_d;
  logic [LEN_W-1:0] sel_full;
  logic [2:0]       sel;
  logic [7:0]       needle_byte;
  logic             in_use;

  // Cell k sees the byte that is k places old; it meets needle byte len-1-k.
  assign in_use      = Idx < cfg_i.len;
  assign sel_full    = cfg_i.len - Idx - LEN_W'(1);
  assign sel         = sel_full[2:0];
  assign needle_byte = cfg_i.needle[{sel, 3'b000} +: 8];
  assign eq_o        = !in_use ||
                       (fold_byte(byte_i, cfg_i.fold) == fold_byte(needle_byte, cfg_i.fold));

  always_comb begin
    byte_d = byte_q;
    if (ctrl_i.shift) begin
      byte_d = ctrl_i.clear ? 8'h00 : byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= 8'h00;
    end else begin
      byte_q <= byte_d;
    end
  end

  assign byte_o = byte_q;

endmodule

[design/bss_out_buf.sv]
// Result register with a skid stage, so the input side keeps taking items
// while a result waits. Depends on bss_pkg.
`timescale 1ns / 1ps

module bss_out_buf import bss_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t push_res_i,
  input  logic    out_stall_i,
  output logic    out_valid_o,
  output result_t out_res_o,
  output logic    skid_full_o
);

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_res_q, out_res_d;
  result_t skid_res_q, skid_res_d;
  logic    out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_res_d    = out_res_q;
    skid_valid_d = skid_valid_q;
    skid_res_d   = skid_res_q;
    if (out_free) begin
      if (skid_valid_q) begin
        // drain the skid stage; no push can arrive while it is full
        out_valid_d  = 1'b1;
        out_res_d    = skid_res_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = push_i;
        out_res_d   = push_res_i;
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_res_d   = push_res_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q  <= out_res_d;
    skid_res_q <= skid_res_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_res_q;
  assign skid_full_o = skid_valid_q;

endmodule

[design/byte_substring_search.sv]
// Streaming substring search: one haystack byte per item, first match offset.
// The result of an item is registered in the output register, or in the skid
// stage while the output stalls. Throughput: one item per cycle, set by the
// row of window cells that shift and compare in parallel; input stalls only
// while the skid stage holds a second waiting result. Reset clears the config
// registers, the valid flags, the window, the byte count and the reported flag.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module byte_substring_search import bss_pkg::*; #(
  parameter int unsigned NEEDLE_MAX = NEEDLE_MAX_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [NEEDLE_W-1:0]  cfg_data_i,
  // haystack items
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [7:0]           data_byte_i,
  input  logic                 last_byte_i,
  // result items
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 found_o,
  output logic [OFFSET_W-1:0]  offset_o
);

  localparam logic [LEN_W-1:0]    LenMax  = LEN_W'(NEEDLE_MAX);
  localparam logic [OFFSET_W-1:0] SeenMax = '1;

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [NEEDLE_W-1:0] needle_q;
  logic [LEN_W-1:0]    len_q;
  logic                fold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      needle_q <= '0;
      len_q    <= '0;
      fold_q   <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_NEEDLE_BYTES:  needle_q <= cfg_data_i;
        REG_NEEDLE_LENGTH: len_q    <= cfg_data_i[LEN_W-1:0];
        REG_FOLD_CASE:     fold_q   <= cfg_data_i[0];
        default: ;  // unused index: drop the write
      endcase
    end
  end

  // Clamp the length to the number of cells in the row.
  needle_cfg_t cfg;
  assign cfg.needle = needle_q;
  assign cfg.len    = (len_q > LenMax) ? LenMax : len_q;
  assign cfg.fold   = fold_q;

  // ---------------------------------------------------------------------
  // Handshake and stream control
  // ---------------------------------------------------------------------
  logic       in_acc;
  logic       skid_full;
  cell_ctrl_t ctrl;

  assign in_stall_o = skid_full;
  assign in_acc     = in_valid_i && !in_stall_o;
  assign ctrl.shift = in_acc;
  assign ctrl.clear = last_byte_i;

  // ---------------------------------------------------------------------
  // Row of window cells: cell 0 takes the new byte, each cell passes its
  // byte to the next. Each cell compares the byte it is about to hold, so
  // the compare sees the window including the current item.
  // ---------------------------------------------------------------------
  logic [7:0]            win [NEEDLE_MAX];
  logic [7:0]            cell_in [NEEDLE_MAX];
  logic [NEEDLE_MAX-1:0] eq;

  for (genvar k = 0; k < NEEDLE_MAX; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign cell_in[k] = data_byte_i;
    end else begin : g_tail
      assign cell_in[k] = win[k-1];
    end

    bss_cell #(
      .CELL_IDX(k)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctrl_i(ctrl),
      .cfg_i (cfg),
      .byte_i(cell_in[k]),
      .byte_o(win[k]),
      .eq_o  (eq[k])
    );
  end

  // ---------------------------------------------------------------------
  // Byte count (saturating) and match bookkeeping
  // ---------------------------------------------------------------------
  logic [OFFSET_W-1:0] seen_q, seen_d, seen_nx;
  logic                reported_q, reported_d;
  logic                hit;
  logic                push;
  result_t             res;

  assign seen_nx = (seen_q == SeenMax) ? seen_q : seen_q + OFFSET_W'(1);

  // A match only counts once the whole needle lies inside the haystack.
  assign hit = (seen_nx >= OFFSET_W'(cfg.len)) && (&eq);

  assign push       = in_acc && !reported_q && (hit || last_byte_i);
  assign res.found  = hit;
  assign res.offset = (hit && cfg.len != '0) ? seen_nx - OFFSET_W'(cfg.len) : '0;

  always_comb begin
    seen_d     = seen_q;
    reported_d = reported_q;
    if (in_acc) begin
      if (last_byte_i) begin
        // end of haystack: start the next one afresh
        seen_d     = '0;
        reported_d = 1'b0;
      end else begin
        seen_d     = seen_nx;
        reported_d = reported_q || hit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q     <= '0;
      reported_q <= 1'b0;
    end else begin
      seen_q     <= seen_d;
      reported_q <= reported_d;
    end
  end

  // ---------------------------------------------------------------------
  // Output register and skid stage
  // ---------------------------------------------------------------------
  result_t out_res;

  bss_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_res_i (res),
    .out_stall_i(out_stall_i),
    .out_valid_o(out_valid_o),
    .out_res_o  (out_res),
    .skid_full_o(skid_full)
  );

  assign found_o  = out_res.found;
  assign offset_o = out_res.offset;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `BSS_ASSERT(a_skid_behind_out, !skid_full || out_valid_o, "skid full with output empty")
  `BSS_ASSERT(a_reported_has_bytes, !reported_q || seen_q != '0, "reported flag with no bytes")
  `BSS_ASSERT(a_one_result, !(push && reported_q), "second result in one haystack")
  `BSS_ASSERT_NEXT(a_hit_marks, push && hit && !last_byte_i, reported_q, "match not recorded")

endmodule
